### design/pms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_pkg
// Shared types and codes of the periodic message scheduler: request and
// response payloads, slot record layout, operation and status codes.
// ----------------------------------------------------------------------------
package pms_pkg;

   // operation codes
   localparam logic [2:0] FUNC_TICK    = 3'd0;
   localparam logic [2:0] FUNC_ADD     = 3'd1;
   localparam logic [2:0] FUNC_DELETE  = 3'd2;
   localparam logic [2:0] FUNC_RELEASE = 3'd3;
   localparam logic [2:0] FUNC_UNQUEUE = 3'd4;
   localparam logic [2:0] FUNC_CLAIM   = 3'd5;

   // status codes
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_ADD_REFUSED = 2'd1;
   localparam logic [1:0] ST_DEL_DEFER   = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND   = 2'd3;

   localparam logic [15:0] NONE_DUE = 16'hFFFF;

   typedef struct packed {
      logic [2:0]  func;
      logic [3:0]  slot_id;
      logic [1:0]  protocol;
      logic [15:0] period_ms;
      logic [3:0]  msg_length;
      logic [15:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  slot_out;
      logic [3:0]  length_out;
      logic [15:0] next_due_ms;
   } rsp_type;

   // one slot record as held in the slot memory
   typedef struct packed {
      logic        enabled;
      logic        fresh;
      logic        txq;
      logic        delq;
      logic        busy;
      logic [1:0]  protocol;
      logic [3:0]  length;
      logic [15:0] period;
      logic [15:0] countdown;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

   // result of the slot unit for one record
   typedef struct packed {
      slot_entry_type entry;
      logic           wr;
      logic           hit;
      logic [1:0]     status;
      logic [15:0]    least;
   } alu_res_type;

endpackage

### design/pms_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_stream_if
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
interface pms_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### design/periodic_message_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_message_scheduler
// Table of periodic-message slots with add, delete, release, unqueue, claim
// and tick operations.
//
// Use: a request on req_chan carries one operation; exactly one response on
// rsp_chan follows for each request. The block takes one request at a time:
// req_chan.ready is high only when no request is in work and the previous
// response has been taken.
// Slot records sit in a single-port-read memory that is walked one record a
// cycle through one shared update unit, with a read issued each cycle and
// the update written back on the next.
// A tick, and a claim that finds nothing, walk every slot; a claim stops at
// the first slot that it can grant. Add, delete, release and unqueue on a
// slot in range read and write back that one slot, and a slot out of range
// or an unused code goes straight to the response. A new request is taken
// only once the response to the last one has been taken.
// Reset clears the per-slot valid bits, so every slot reads as disabled
// straight away; no clearing pass is run.
// A stalled receiver holds the response in its register and no new request
// is taken until it goes.
// ----------------------------------------------------------------------------
module periodic_message_scheduler #(
   parameter int SLOTS = 16
) (
   input logic  clock,
   input logic  reset,
   pms_stream_if.sink   req_chan,
   pms_stream_if.source rsp_chan
);
   import pms_pkg::*;

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type      state_ff, state_in;
   req_type        req_ff, req_in;
   logic           issue_ff, issue_in;
   logic           pend_ff, pend_in;
   logic           stop_ff, stop_in;
   logic [AW-1:0]  rd_idx_ff, rd_idx_in;
   logic [AW-1:0]  last_ff, last_in;
   logic [AW-1:0]  pend_idx_ff, pend_idx_in;
   logic           rvalid_ff, rvalid_in;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [1:0]     status_ff, status_in;
   logic [3:0]     slot_ff, slot_in;
   logic [3:0]     len_ff, len_in;
   logic [15:0]    least_ff, least_in;

   req_type        req_p;
   logic           req_fire;
   logic           in_range;
   logic [AW-1:0]  id_addr;
   logic           ram_wr;
   logic [ENTRY_W-1:0] ram_rdata;
   slot_entry_type entry_rd;
   alu_res_type    alu;
   rsp_type        rsp_p;

   assign req_p    = req_chan.payload;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign in_range = 32'(req_p.slot_id) < SLOTS;
   assign id_addr  = AW'(req_p.slot_id);

   // never-written slots read as all zero
   assign entry_rd = rvalid_ff ? slot_entry_type'(ram_rdata) : '0;

   pms_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (pend_idx_ff),
      .wr_data (alu.entry),
      .rd_en   (issue_ff),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rdata)
   );

   pms_slot_alu u_alu (
      .req      (req_ff),
      .entry_in (entry_rd),
      .least_in (least_ff),
      .res      (alu)
   );

   assign ram_wr = (state_ff == S_SCAN) && pend_ff && !stop_ff && alu.wr;

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      issue_in    = issue_ff;
      pend_in     = 1'b0;
      stop_in     = stop_ff;
      rd_idx_in   = rd_idx_ff;
      last_in     = last_ff;
      pend_idx_in = rd_idx_ff;
      rvalid_in   = valid_ff[rd_idx_ff];
      valid_in    = valid_ff;
      status_in   = status_ff;
      slot_in     = slot_ff;
      len_in      = len_ff;
      least_in    = least_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               req_in    = req_p;
               stop_in   = 1'b0;
               status_in = ST_OK;
               slot_in   = '0;
               len_in    = '0;
               least_in  = '0;
               unique case (req_p.func)
                  FUNC_TICK, FUNC_CLAIM: begin
                     state_in  = S_SCAN;
                     issue_in  = 1'b1;
                     rd_idx_in = '0;
                     last_in   = AW'(SLOTS - 1);
                     if (req_p.func == FUNC_TICK) begin
                        least_in = NONE_DUE;
                     end else begin
                        status_in = ST_NOT_FOUND;
                     end
                  end
                  FUNC_ADD, FUNC_DELETE, FUNC_RELEASE, FUNC_UNQUEUE: begin
                     if (in_range) begin
                        state_in  = S_SCAN;
                        issue_in  = 1'b1;
                        rd_idx_in = id_addr;
                        last_in   = id_addr;
                     end else begin
                        state_in = S_DONE;
                        if (req_p.func == FUNC_ADD) begin
                           status_in = ST_ADD_REFUSED;
                        end
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            pend_in = issue_ff;
            if (issue_ff) begin
               if (rd_idx_ff == last_ff) begin
                  issue_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + 1'b1;
               end
            end
            if (pend_ff && !stop_ff) begin
               if (alu.wr) begin
                  valid_in[pend_idx_ff] = 1'b1;
               end
               unique case (req_ff.func)
                  FUNC_TICK: begin
                     least_in = alu.least;
                  end
                  FUNC_CLAIM: begin
                     if (alu.hit) begin
                        // lowest match wins, later reads are dropped
                        stop_in   = 1'b1;
                        issue_in  = 1'b0;
                        status_in = ST_OK;
                        slot_in   = 4'(pend_idx_ff);
                        len_in    = entry_rd.length;
                     end
                  end
                  default: begin
                     status_in = alu.status;
                  end
               endcase
            end
            if (!issue_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         issue_ff <= 1'b0;
         pend_ff  <= 1'b0;
         stop_ff  <= 1'b0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
         pend_ff  <= pend_in;
         stop_ff  <= stop_in;
         valid_ff <= valid_in;
      end
      req_ff      <= req_in;
      rd_idx_ff   <= rd_idx_in;
      last_ff     <= last_in;
      pend_idx_ff <= pend_idx_in;
      rvalid_ff   <= rvalid_in;
      status_ff   <= status_in;
      slot_ff     <= slot_in;
      len_ff      <= len_in;
      least_ff    <= least_in;
   end

   always_comb begin
      rsp_p.status      = status_ff;
      rsp_p.slot_out    = slot_ff;
      rsp_p.length_out  = len_ff;
      rsp_p.next_due_ms = least_ff;
   end

   assign rsp_chan.valid   = (state_ff == S_DONE);
   assign rsp_chan.payload = rsp_p;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("scheduler state not one-hot");

   a_pend_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == S_SCAN)
      else $error("read data pending outside the scan");

   a_wr_in_scan: assert property (@(posedge clock) disable iff (reset)
      ram_wr |-> state_ff == S_SCAN && !stop_ff)
      else $error("slot write outside the scan");

   a_fire_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != S_IDLE)
      else $error("request accepted but no work started");

   a_none_only_claim: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && status_ff == ST_NOT_FOUND |-> req_ff.func == FUNC_CLAIM)
      else $error("claim-none status on another operation");
endmodule

### design/pms_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module pms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### design/pms_slot_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_slot_alu
// Update unit shared by every slot: applies one operation to one slot
// record, ages the countdown on a tick and folds it into the running minimum.
// ----------------------------------------------------------------------------
module pms_slot_alu (
   input  pms_pkg::req_type        req,
   input  pms_pkg::slot_entry_type entry_in,
   input  logic [15:0]             least_in,
   output pms_pkg::alu_res_type    res
);
   import pms_pkg::*;

   logic        active;
   logic [15:0] cd;
   logic        due;
   logic [15:0] cd_next;

   assign active  = entry_in.enabled && !entry_in.busy;
   // a fresh slot comes due at once
   assign cd      = entry_in.fresh ? 16'd0 : entry_in.countdown;
   assign due     = cd <= req.elapsed_ms;
   assign cd_next = due ? entry_in.period : 16'(cd - req.elapsed_ms);

   always_comb begin
      res        = '0;
      res.entry  = entry_in;
      res.status = ST_OK;
      res.least  = least_in;
      unique case (req.func)
         FUNC_TICK: begin
            if (active) begin
               res.wr              = 1'b1;
               res.entry.fresh     = 1'b0;
               res.entry.txq       = entry_in.txq | due;
               res.entry.countdown = cd_next;
               if (cd_next <= least_in) begin
                  res.least = cd_next;
               end
            end
         end
         FUNC_ADD: begin
            if (entry_in.enabled) begin
               res.status = ST_ADD_REFUSED;
            end else begin
               res.wr             = 1'b1;
               res.entry.enabled  = 1'b1;
               res.entry.fresh    = 1'b1;
               res.entry.txq      = 1'b0;
               res.entry.delq     = 1'b0;
               res.entry.busy     = 1'b0;
               res.entry.protocol = req.protocol;
               res.entry.length   = req.msg_length;
               res.entry.period   = req.period_ms;
            end
         end
         FUNC_DELETE: begin
            if (entry_in.enabled) begin
               res.wr = 1'b1;
               if (entry_in.busy) begin
                  res.entry.delq = 1'b1;
                  res.status     = ST_DEL_DEFER;
               end else begin
                  res.entry           = '0;
                  res.entry.countdown = entry_in.countdown;
               end
            end
         end
         FUNC_RELEASE: begin
            res.wr = 1'b1;
            if (entry_in.delq) begin
               res.entry           = '0;
               res.entry.countdown = entry_in.countdown;
            end else begin
               res.entry.busy = 1'b0;
            end
         end
         FUNC_UNQUEUE: begin
            res.wr        = 1'b1;
            res.entry.txq = 1'b0;
         end
         FUNC_CLAIM: begin
            if (active && entry_in.txq && entry_in.protocol == req.protocol) begin
               res.wr         = 1'b1;
               res.hit        = 1'b1;
               res.entry.busy = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end
endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives operation requests into the periodic message scheduler and checks
// every response against a slot table kept alongside it. A short directed
// pass covers each operation and corner, then random traffic runs with
// random gaps on both channels, without gaps, and under a long response
// hold-off.
// ----------------------------------------------------------------------------
module testbench;
   import pms_pkg::*;

   localparam int          SLOTS      = 16;
   localparam int unsigned CYCLE_CAP  = 600000;
   localparam logic [2:0]  FUNC_SPARE_6 = 3'd6;
   localparam logic [2:0]  FUNC_SPARE_7 = 3'd7;

   logic clock = 1'b0;
   logic reset;

   pms_stream_if #(.payload_type(req_type)) req_chan ();
   pms_stream_if #(.payload_type(rsp_type)) rsp_chan ();

   periodic_message_scheduler #(
      .SLOTS (SLOTS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   slot_entry_type slot_table [SLOTS];
   rsp_type        sched_replies [$];

   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;
   int unsigned rsp_hold_cycles = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned replies_checked = 0;
   int unsigned ops_seen [8];
   int unsigned claims_granted = 0;
   int unsigned adds_refused = 0;
   int unsigned deletes_deferred = 0;
   int unsigned claims_empty = 0;

   function automatic void free_slot(int i);
      logic [15:0] keep;
      keep = slot_table[i].countdown;
      slot_table[i] = '0;
      slot_table[i].countdown = keep;
   endfunction

   // applies one request to the slot table and returns the reply it implies
   function automatic rsp_type schedule_op(req_type r);
      rsp_type res;
      int      id;
      logic [15:0] least;
      res = '0;
      id = int'(r.slot_id);
      case (r.func)
         FUNC_TICK: begin
            least = NONE_DUE;
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_table[i].enabled && !slot_table[i].busy) begin
                  if (slot_table[i].fresh) begin
                     slot_table[i].countdown = '0;
                     slot_table[i].fresh = 1'b0;
                  end
                  if (slot_table[i].countdown <= r.elapsed_ms) begin
                     slot_table[i].txq = 1'b1;
                     slot_table[i].countdown = slot_table[i].period;
                  end else begin
                     slot_table[i].countdown = slot_table[i].countdown - r.elapsed_ms;
                  end
                  if (slot_table[i].countdown <= least) least = slot_table[i].countdown;
               end
            end
            res.next_due_ms = least;
         end
         FUNC_ADD: begin
            if (slot_table[id].enabled) begin
               res.status = ST_ADD_REFUSED;
            end else begin
               slot_table[id].enabled  = 1'b1;
               slot_table[id].fresh    = 1'b1;
               slot_table[id].txq      = 1'b0;
               slot_table[id].delq     = 1'b0;
               slot_table[id].busy     = 1'b0;
               slot_table[id].protocol = r.protocol;
               slot_table[id].length   = r.msg_length;
               slot_table[id].period   = r.period_ms;
            end
         end
         FUNC_DELETE: begin
            if (slot_table[id].enabled) begin
               if (slot_table[id].busy) begin
                  slot_table[id].delq = 1'b1;
                  res.status = ST_DEL_DEFER;
               end else begin
                  free_slot(id);
               end
            end
         end
         FUNC_RELEASE: begin
            if (slot_table[id].delq) free_slot(id);
            slot_table[id].busy = 1'b0;
         end
         FUNC_UNQUEUE: begin
            slot_table[id].txq = 1'b0;
         end
         FUNC_CLAIM: begin
            res.status = ST_NOT_FOUND;
            for (int i = 0; i < SLOTS; i++) begin
               if (res.status == ST_NOT_FOUND && slot_table[i].enabled &&
                   slot_table[i].txq && !slot_table[i].busy &&
                   slot_table[i].protocol == r.protocol) begin
                  slot_table[i].busy = 1'b1;
                  res.status     = ST_OK;
                  res.slot_out   = 4'(i);
                  res.length_out = slot_table[i].length;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      pick;
      int      start;
      r.func       = FUNC_TICK;
      r.slot_id    = 4'($urandom_range(0, SLOTS - 1));
      r.protocol   = 2'($urandom_range(0, 3));
      r.msg_length = 4'($urandom_range(0, 15));
      // mostly short periods and steps so slots come due often
      r.period_ms  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
      r.elapsed_ms = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 120));
      pick = $urandom_range(0, 99);
      if (pick < 25)      r.func = FUNC_TICK;
      else if (pick < 45) r.func = FUNC_ADD;
      else if (pick < 55) r.func = FUNC_DELETE;
      else if (pick < 67) r.func = FUNC_RELEASE;
      else if (pick < 75) r.func = FUNC_UNQUEUE;
      else if (pick < 96) r.func = FUNC_CLAIM;
      else                r.func = $urandom_range(0, 1) ? FUNC_SPARE_6 : FUNC_SPARE_7;
      // releases and deletes mostly aim at a slot that is actually held
      if ((r.func == FUNC_RELEASE || r.func == FUNC_DELETE) && $urandom_range(0, 9) < 6) begin
         start = $urandom_range(0, SLOTS - 1);
         for (int k = 0; k < SLOTS; k++) begin
            if (slot_table[(start + k) % SLOTS].busy) r.slot_id = 4'((start + k) % SLOTS);
         end
      end
      return r;
   endfunction

   task automatic send_request(req_type r);
      int unsigned gap;
      rsp_type     want;
      gap = req_idle_on ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= r;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      want = schedule_op(r);
      sched_replies.push_back(want);
      ops_seen[r.func]++;
      if (r.func == FUNC_CLAIM && want.status == ST_OK)        claims_granted++;
      if (r.func == FUNC_CLAIM && want.status == ST_NOT_FOUND) claims_empty++;
      if (want.status == ST_ADD_REFUSED)                       adds_refused++;
      if (want.status == ST_DEL_DEFER)                         deletes_deferred++;
   endtask

   task automatic send_op(logic [2:0] func, int id, int prot, int per, int len, int step);
      req_type r;
      r.func       = func;
      r.slot_id    = 4'(id);
      r.protocol   = 2'(prot);
      r.period_ms  = 16'(per);
      r.msg_length = 4'(len);
      r.elapsed_ms = 16'(step);
      send_request(r);
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (sched_replies.size() != 0) @(posedge clock);
      repeat (SLOTS + 4) @(posedge clock);
   endtask

   task automatic test_reset_state();
      // empty table: nothing due and nothing to claim
      send_op(FUNC_TICK, 0, 0, 0, 0, 0);
      send_op(FUNC_CLAIM, 0, 0, 0, 0, 0);
      send_op(FUNC_DELETE, 3, 0, 0, 0, 0);
      send_op(FUNC_RELEASE, 5, 0, 0, 0, 0);
   endtask

   task automatic test_directed_ops();
      send_op(FUNC_ADD, 0, 3, 16'hFFFF, 15, 16'hFFFF);
      send_op(FUNC_ADD, 0, 1, 10, 4, 0);              // occupied slot refused
      send_op(FUNC_ADD, 15, 0, 0, 0, 0);              // zero period and length
      send_op(FUNC_TICK, 0, 0, 0, 0, 0);              // new slots come due at once
      send_op(FUNC_TICK, 0, 0, 0, 0, 16'hFFFF);
      send_op(FUNC_CLAIM, 0, 3, 0, 0, 0);
      send_op(FUNC_CLAIM, 0, 3, 0, 0, 0);             // already held, none left
      send_op(FUNC_DELETE, 0, 0, 0, 0, 0);            // busy: deferred
      send_op(FUNC_ADD, 0, 2, 5, 1, 0);               // refused while delete pending
      send_op(FUNC_TICK, 0, 0, 0, 0, 1);              // busy slot skipped
      send_op(FUNC_RELEASE, 0, 0, 0, 0, 0);           // completes the deferred delete
      send_op(FUNC_UNQUEUE, 15, 0, 0, 0, 0);
      send_op(FUNC_CLAIM, 0, 0, 0, 0, 0);             // unqueued, so nothing found
      send_op(FUNC_TICK, 0, 0, 0, 0, 0);
      send_op(FUNC_CLAIM, 0, 0, 0, 0, 0);
      send_op(FUNC_RELEASE, 15, 0, 0, 0, 0);          // plain release keeps the slot
      send_op(FUNC_DELETE, 15, 0, 0, 0, 0);
      send_op(FUNC_SPARE_6, 9, 2, 16'hFFFF, 15, 16'hFFFF);
      send_op(FUNC_SPARE_7, 15, 3, 16'hFFFF, 15, 16'hFFFF);
      send_op(FUNC_TICK, 0, 0, 0, 0, 16'hFFFF);
   endtask

   task automatic run_random(int unsigned count);
      req_type     r;
      int unsigned done;
      done = 0;
      while (done < count) begin
         r = random_request();
         send_request(r);
         if (r.func <= FUNC_CLAIM) done++;
      end
   endtask

   task automatic test_random_traffic(int unsigned count);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      run_random(count);
   endtask

   task automatic test_back_to_back(int unsigned count);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      run_random(count);
   endtask

   task automatic test_backpressure(int unsigned count);
      // receiver sits on a response while requests keep coming
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b1;
      rsp_hold_cycles = 240;
      run_random(20);
      req_idle_on = 1'b1;
      run_random(count);
   endtask

   initial begin
      rsp_chan.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin : response_drain
         int unsigned stall;
         if (rsp_hold_cycles != 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = rsp_idle_on ? $urandom_range(0, 17) : 0;
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   always @(posedge clock) begin : check_replies
      rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (sched_replies.size() == 0) begin
            $error("response with no request outstanding: %h", rsp_chan.payload);
            mismatches++;
         end else begin
            want = sched_replies.pop_front();
            replies_checked++;
            if (rsp_chan.payload.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status,
                      rsp_chan.payload.status);
               mismatches++;
            end
            if (rsp_chan.payload.slot_out !== want.slot_out) begin
               $error("slot_out expected %0d actual %0d", want.slot_out,
                      rsp_chan.payload.slot_out);
               mismatches++;
            end
            if (rsp_chan.payload.length_out !== want.length_out) begin
               $error("length_out expected %0d actual %0d", want.length_out,
                      rsp_chan.payload.length_out);
               mismatches++;
            end
            if (rsp_chan.payload.next_due_ms !== want.next_due_ms) begin
               $error("next_due_ms expected %0d actual %0d", want.next_due_ms,
                      rsp_chan.payload.next_due_ms);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_CAP) begin
         $display("timed out after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < SLOTS; i++) slot_table[i] = '0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_directed_ops();
      test_random_traffic(560);
      test_back_to_back(250);
      test_backpressure(160);
      wait_idle();

      $display("covered %0d responses: %0d tick, %0d add, %0d delete, %0d release,",
               replies_checked, ops_seen[FUNC_TICK], ops_seen[FUNC_ADD],
               ops_seen[FUNC_DELETE], ops_seen[FUNC_RELEASE]);
      $display("%0d unqueue, %0d claim; claims granted %0d, empty %0d; adds refused %0d; deletes deferred %0d",
               ops_seen[FUNC_UNQUEUE], ops_seen[FUNC_CLAIM],
               claims_granted, claims_empty, adds_refused, deletes_deferred);
      if (mismatches == 0 && sched_replies.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
